// File: design/cnv_pkg.sv
// Shared types and constants of the RGB 3x3 convolution core.
// Used by the front, queue and back modules and the top level.
`default_nettype none

package cnv_pkg;

    // Kernel geometry and pixel range.
    localparam int KERNEL_SIZE = 3;
    localparam int NTAPS       = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIX_MAX     = 255;

    // Arithmetic widths: 8-bit unsigned channel times 16-bit signed coefficient.
    localparam int PROD_W    = 25;
    localparam int SUM_W     = 28;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_STEPS = MAG_W;

    // Job queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Item types on the input channel.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_KROW_TOP    = 3'd0,
        CFG_KROW_MIDDLE = 3'd1,
        CFG_KROW_BOTTOM = 3'd2,
        CFG_SCALE       = 3'd3,
        CFG_WIDTH       = 3'd4,
        CFG_HEIGHT      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_READ,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MAC,
        BS_PREP,
        BS_DIV,
        BS_OUT
    } t_back_state;

    // One output pixel to compute: nine neighborhood pixels (index row*3+col),
    // which taps lie inside the frame, and the end-of-frame flag.
    typedef struct packed {
        logic [NTAPS-1:0][23:0] taps;
        logic [NTAPS-1:0]       mask;
        logic                   eof;
    } t_job;

    typedef struct packed {
        logic [10:0] width;
        logic [12:0] height;
    } t_front_cfg;

    typedef struct packed {
        logic [2:0][47:0] krow;
        logic [15:0]      scale;
    } t_back_cfg;

    // Tap enables from the row and column validity of the window.
    function automatic logic [NTAPS-1:0] tap_mask(input logic [2:0] rv, input logic [2:0] cv);
        logic [NTAPS-1:0] m;
        for (int x = 0; x < KERNEL_SIZE; x++) begin
            for (int y = 0; y < KERNEL_SIZE; y++) begin
                m[x*KERNEL_SIZE+y] = rv[x] & cv[y];
            end
        end
        return m;
    endfunction

    // Kernel row of a tap index.
    function automatic logic [1:0] tap_row(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // Kernel column of a tap index.
    function automatic logic [1:0] tap_col(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/cnv_ifs.sv
// Handshake channel interfaces of the convolution core: pixel in, pixel out, config.
// Stand alone; no package needed.
`default_nettype none

interface cnv_pix_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface cnv_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_frame;
    modport source (output valid, red_out, green_out, blue_out, end_of_frame, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, end_of_frame, output ready);
endinterface

interface cnv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/cnv_front.sv
// Front of the convolution core: accepts items, keeps the line buffers and window,
// and turns each item into zero, one or two jobs. Depends on cnv_pkg and cnv_ifs.
`default_nettype none

module cnv_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cnv_pix_in_if.sink          i_pix,
    input  cnv_pkg::t_front_cfg i_cfg,
    output cnv_pkg::t_job       o_job,
    output logic                o_job_valid,
    input  logic                i_job_ready
);
    import cnv_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

    t_front_state r_state, n_state;
    logic [12:0]            r_row;
    logic [AW-1:0]          r_col;
    logic [23:0]            r_mem0 [MAX_WIDTH];
    logic [23:0]            r_mem1 [MAX_WIDTH];
    logic [23:0]            r_rd0, r_rd1, r_pix;
    logic [2:0][2:0][23:0]  r_win;
    logic                   r_p1, r_p2, r_e1, r_e2;
    logic [NTAPS-1:0]       r_m1, r_m2;

    logic [WW-1:0] w_ext, w_max, weff, c_ext;
    logic [WW:0]   c_inc;
    logic [12:0]   heff;
    logic          flushing, accept, item_ok, last, push;
    logic          job1_ok, job2_ok, eof1, eof2;
    logic [2:0]    rv, cv1, cv2;

    // Effective frame size and position tests.
    always_comb begin
        w_ext    = WW'(i_cfg.width);
        w_max    = WW'(MAX_WIDTH);
        weff     = (w_ext == '0) ? WW'(1) : ((w_ext > w_max) ? w_max : w_ext);
        heff     = (i_cfg.height == '0) ? 13'd1 : i_cfg.height;
        flushing = (r_row >= heff);
        c_ext    = WW'(r_col);
        c_inc    = {1'b0, c_ext} + (WW+1)'(1);
        last     = (c_ext >= weff - WW'(1));
        accept   = i_pix.valid && i_pix.ready;
        item_ok  = (i_pix.req_type == REQ_FLUSH) == flushing;
        push     = o_job_valid && i_job_ready;
        job1_ok  = (r_row != '0) && (r_col != '0);
        job2_ok  = (r_row != '0) && last;
        rv       = {r_row < heff, 1'b1, r_row >= 13'd2};
        cv1      = {c_ext < weff, 1'b1, c_ext >= WW'(2)};
        cv2      = {c_inc < {1'b0, weff}, 1'b1, r_col != '0};
        eof1     = (r_row == heff) && (c_ext == weff);
        eof2     = (r_row == heff) && (c_ext == weff - WW'(1));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: if (accept && item_ok) n_state = FS_READ;
            FS_READ: n_state = (job1_ok || job2_ok) ? FS_PUSH : FS_IDLE;
            FS_PUSH: if (push && !(r_p1 && r_p2)) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    // Outputs: the pending job is built from the window after the shift.
    always_comb begin
        i_pix.ready = (r_state == FS_IDLE);
        o_job_valid = (r_state == FS_PUSH);
        o_job       = '0;
        for (int x = 0; x < KERNEL_SIZE; x++) begin
            if (r_p1) begin
                for (int y = 0; y < KERNEL_SIZE; y++) begin
                    o_job.taps[x*KERNEL_SIZE+y] = r_win[x][y];
                end
            end else begin
                for (int y = 0; y < KERNEL_SIZE - 1; y++) begin
                    o_job.taps[x*KERNEL_SIZE+y] = r_win[x][y+1];
                end
            end
        end
        o_job.mask = r_p1 ? r_m1 : r_m2;
        o_job.eof  = r_p1 ? r_e1 : r_e2;
    end

    // Control state: position, window and pending jobs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
            r_win   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                FS_READ: begin
                    r_p1 <= job1_ok;
                    r_p2 <= job2_ok;
                    for (int x = 0; x < KERNEL_SIZE; x++) begin
                        r_win[x][0] <= r_win[x][1];
                        r_win[x][1] <= r_win[x][2];
                    end
                    r_win[0][2] <= r_rd1;
                    r_win[1][2] <= r_rd0;
                    r_win[2][2] <= r_pix;
                    if (last) begin
                        r_col <= '0;
                        r_row <= flushing ? 13'd0 : r_row + 13'd1;
                    end else begin
                        r_col <= r_col + AW'(1);
                    end
                end
                FS_PUSH: begin
                    if (push) begin
                        if (r_p1) r_p1 <= 1'b0;
                        else r_p2 <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers of the item at work.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= (i_pix.req_type == REQ_FLUSH) ? 24'd0
                   : {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        end
        if (r_state == FS_READ) begin
            r_m1 <= tap_mask(rv, cv1);
            r_m2 <= tap_mask(rv, cv2);
            r_e1 <= eof1;
            r_e2 <= eof2;
        end
    end

    // Line buffers: read on accept, written back in the read state that follows.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd0 <= r_mem0[r_col];
            r_rd1 <= r_mem1[r_col];
        end
        if (r_state == FS_READ) begin
            r_mem1[r_col] <= r_rd0;
            r_mem0[r_col] <= r_pix;
        end
    end

    a_push_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_PUSH) |-> (r_p1 || r_p2))
        else $error("front holds no job in the push state");

endmodule

`default_nettype wire

// File: design/cnv_fifo.sv
// Short job queue between the front and the back of the convolution core.
// Depends on cnv_pkg.
`default_nettype none

module cnv_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  cnv_pkg::t_job i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output cnv_pkg::t_job o_pop_data,
    input  logic          i_pop_ready
);
    import cnv_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;
    logic           push, pop;

    // Handshake and head of the queue.
    always_comb begin
        o_push_ready = (r_cnt != (QAW+1)'(QDEPTH));
        o_pop_valid  = (r_cnt != '0);
        o_pop_data   = r_mem[r_rd];
        push         = i_push_valid && o_push_ready;
        pop          = o_pop_valid && i_pop_ready;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + QAW'(1);
            if (pop) r_rd <= r_rd + QAW'(1);
            if (push && !pop) r_cnt <= r_cnt + (QAW+1)'(1);
            else if (pop && !push) r_cnt <= r_cnt - (QAW+1)'(1);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push_data;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + (QAW+1)'(1)))
        else $error("queue count did not follow a push");

    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - (QAW+1)'(1)))
        else $error("queue count did not follow a pop");

endmodule

`default_nettype wire

// File: design/cnv_back.sv
// Back of the convolution core: multiply-accumulate of one job, division by the
// scale, clamping and the output register. Depends on cnv_pkg and cnv_ifs.
`default_nettype none

module cnv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cnv_pkg::t_back_cfg i_cfg,
    input  logic               i_job_valid,
    input  cnv_pkg::t_job      i_job,
    output logic               o_job_ready,
    cnv_pix_out_if.source      o_pix
);
    import cnv_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [3:0]  r_k;
    logic [4:0]  r_cnt;
    logic [15:0] r_d;

    logic signed [2:0][PROD_W-1:0] r_prod;
    logic signed [2:0][SUM_W-1:0]  r_acc;
    logic        [2:0][MAG_W-1:0]  r_q;
    logic        [2:0][15:0]       r_rem;
    logic        [2:0]             r_neg;

    logic signed [15:0]        coef;
    logic        [1:0]         trow, tcol;
    logic signed [2:0][PROD_W-1:0] prod;
    logic        [2:0][16:0]   trial;
    logic        [2:0][7:0]    pix_out;
    logic                      take, give;

    // Products of the current tap, one multiplier per channel.
    always_comb begin
        trow = tap_row(r_k);
        tcol = tap_col(r_k);
        coef = $signed(i_cfg.krow[trow][{tcol, 4'b0000} +: 16]);
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = r_job.mask[r_k]
                ? PROD_W'($signed({1'b0, r_job.taps[r_k][23-8*ch -: 8]}) * coef)
                : '0;
            trial[ch] = {r_rem[ch], r_q[ch][MAG_W-1]};
            pix_out[ch] = r_neg[ch] ? 8'd0
                : ((r_q[ch] > MAG_W'(PIX_MAX)) ? 8'(PIX_MAX) : r_q[ch][7:0]);
        end
        take = i_job_valid && o_job_ready;
        give = o_pix.valid && o_pix.ready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: if (take) n_state = BS_MAC;
            BS_MAC:  if (r_k == 4'(NTAPS)) n_state = BS_PREP;
            BS_PREP: n_state = BS_DIV;
            BS_DIV:  if (r_cnt == 5'(DIV_STEPS - 1)) n_state = BS_OUT;
            BS_OUT:  if (give) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_job_ready        = (r_state == BS_IDLE);
        o_pix.valid        = (r_state == BS_OUT);
        o_pix.red_out      = pix_out[0];
        o_pix.green_out    = pix_out[1];
        o_pix.blue_out     = pix_out[2];
        o_pix.end_of_frame = r_job.eof;
    end

    // Control state and step counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                BS_IDLE: r_k <= '0;
                BS_MAC:  r_k <= r_k + 4'd1;
                BS_PREP: r_cnt <= '0;
                BS_DIV:  r_cnt <= r_cnt + 5'd1;
                default: ;
            endcase
        end
    end

    // Datapath: accumulate registered products, then restoring division.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (take) r_job <= i_job;
                r_acc <= '0;
            end
            BS_MAC: begin
                if (r_k != 4'(NTAPS)) r_prod <= prod;
                if (r_k != '0) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_acc[ch] <= r_acc[ch] + SUM_W'($signed(r_prod[ch]));
                    end
                end
            end
            BS_PREP: begin
                r_d <= (i_cfg.scale == '0) ? 16'd1 : i_cfg.scale;
                for (int ch = 0; ch < 3; ch++) begin
                    r_neg[ch] <= r_acc[ch][SUM_W-1];
                    r_q[ch]   <= r_acc[ch][SUM_W-1] ? MAG_W'(-r_acc[ch]) : MAG_W'(r_acc[ch]);
                    r_rem[ch] <= '0;
                end
            end
            BS_DIV: begin
                for (int ch = 0; ch < 3; ch++) begin
                    if (trial[ch] >= {1'b0, r_d}) begin
                        r_rem[ch] <= 16'(trial[ch] - {1'b0, r_d});
                        r_q[ch]   <= {r_q[ch][MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem[ch] <= trial[ch][15:0];
                        r_q[ch]   <= {r_q[ch][MAG_W-2:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DIV) |-> (r_cnt < 5'(DIV_STEPS)))
        else $error("division ran past its step count");

    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pix.valid) |-> ($past(r_state) == BS_DIV))
        else $error("result shown without a finished division");

endmodule

`default_nettype wire

// File: design/rgb_convolution_3x3_core.sv
// Top level of the RGB 3x3 convolution core: configuration registers and the
// front, job queue and back. Depends on cnv_pkg, cnv_ifs and the three submodules.
//
// Pixels enter in raster order on i_pix; each output pixel is the 3x3 convolution
// of its neighborhood (outside the frame counts as zero), divided by the scale
// with truncation toward zero and clamped to 0..255. Output (r-1,c-1) follows
// input (r,c), the right edge pixel follows each row's last input, and after a
// frame one row of flush items drains the last row. The front accepts an item in
// its idle state, reads the line buffers and pushes each of its results as a job
// in its push state, waiting while the queue is full; items of the wrong type are
// dropped on accept. The back takes a job only while idle, runs the nine taps
// through one multiplier per channel, sets up, divides bit-serially and holds
// the result until it is taken. A four-entry job queue lets the front run ahead
// of the back. The user must write configuration on i_cfg only while the core is
// idle (not enforced by the core); indexes beyond the register list are ignored.
`default_nettype none

module rgb_convolution_3x3_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cnv_pix_in_if.sink    i_pix,
    cnv_pix_out_if.source o_pix,
    cnv_cfg_if.sink       i_cfg
);
    import cnv_pkg::*;

    logic [2:0][47:0] r_krow;
    logic [15:0]      r_scale;
    logic [10:0]      r_width;
    logic [12:0]      r_height;

    t_front_cfg front_cfg;
    t_back_cfg  back_cfg;
    t_job       push_job, pop_job;
    logic       push_valid, push_ready, pop_valid, pop_ready;

    // Configuration register writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow   <= {48'd0, 48'd65536, 48'd0};
            r_scale  <= 16'd1;
            r_width  <= 11'd1024;
            r_height <= 13'd768;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_KROW_TOP:    r_krow[0] <= i_cfg.data;
                CFG_KROW_MIDDLE: r_krow[1] <= i_cfg.data;
                CFG_KROW_BOTTOM: r_krow[2] <= i_cfg.data;
                CFG_SCALE:       r_scale   <= i_cfg.data[15:0];
                CFG_WIDTH:       r_width   <= i_cfg.data[10:0];
                CFG_HEIGHT:      r_height  <= i_cfg.data[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        front_cfg.width  = r_width;
        front_cfg.height = r_height;
        back_cfg.krow    = r_krow;
        back_cfg.scale   = r_scale;
    end

    cnv_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (front_cfg),
        .o_job       (push_job),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready)
    );

    cnv_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_job),
        .i_pop_ready  (pop_ready)
    );

    cnv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_job_valid (pop_valid),
        .i_job       (pop_job),
        .o_job_ready (pop_ready),
        .o_pix       (o_pix)
    );

endmodule

`default_nettype wire
